// ===== src/drmseq_pkg.sv =====
package drmseq_pkg;

    localparam int TIME_W    = 24;
    localparam int SEC_W     = 16;
    localparam int DUR_W     = 8;
    localparam int TOTAL_W   = 10;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_FWD = 2'd1,
        MODE_REV = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_START  = 3'd1,
        KIND_STOP   = 3'd2,
        KIND_MANFWD = 3'd3,
        KIND_MANREV = 3'd4,
        KIND_MANOFF = 3'd5
    } t_kind;

endpackage

// ===== src/drum_reversing_motor_sequencer_top.sv =====
// A start, stop, manual or idle tick word gives its result in the cycle after acceptance.
// A tick during a rotation with a non-zero cycle total gives its result once the
// bit-serial remainder unit, which takes one dividend bit per cycle, has handed its
// remainder over.
// One word is processed at a time; a new word is taken once the previous result is taken.
// Synchronous active-low reset clears the state, the level times and the result valid.
module drum_reversing_motor_sequencer_top
    import drmseq_pkg::*;
#(
    parameter int LEVEL_COUNT = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_kind,
    input  logic [7:0]           i_level,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_motor_mode,
    output logic                 o_rotation_active,
    output logic [1:0]           o_active_level,
    output logic [SEC_W-1:0]     o_elapsed_seconds,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state              r_state;
    logic [TIME_W-1:0]   r_times [LEVEL_COUNT];
    logic [SEC_W-1:0]    r_count;
    logic                r_running;
    logic [1:0]          r_level;
    t_mode               r_mode;
    logic                r_out_valid;

    logic [TIME_W-1:0]   w_sel;
    logic [TOTAL_W-1:0]  w_fwd;
    logic [TOTAL_W-1:0]  w_rev;
    logic [TOTAL_W-1:0]  w_pause;
    logic [TOTAL_W-1:0]  w_fp;
    logic [TOTAL_W-1:0]  w_fpr;
    logic [TOTAL_W-1:0]  w_total;
    logic [TOTAL_W-1:0]  w_rem;
    logic                w_mod_done;
    logic                w_mod_start;
    logic                w_in_acc;
    logic                w_level_ok;
    t_mode               w_phase;
    t_kind               w_kind;

    always_comb begin
        w_sel = '0;
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            if (r_level == 2'(i + 1)) begin
                w_sel = r_times[i];
            end
        end
    end

    assign w_fwd   = {2'b00, w_sel[DUR_W-1:0]};
    assign w_rev   = {2'b00, w_sel[2*DUR_W-1:DUR_W]};
    assign w_pause = {2'b00, w_sel[3*DUR_W-1:2*DUR_W]};
    assign w_fp    = w_fwd + w_pause;
    assign w_fpr   = w_fp + w_rev;
    assign w_total = w_fpr + w_pause;

    always_comb begin
        if (w_rem < w_fwd) begin
            w_phase = MODE_FWD;
        end else if (w_rem < w_fp) begin
            w_phase = MODE_OFF;
        end else if (w_rem < w_fpr) begin
            w_phase = MODE_REV;
        end else begin
            w_phase = MODE_OFF;
        end
    end

    assign w_kind      = t_kind'(i_kind);
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_level_ok  = (i_level >= 8'd1) && (i_level <= 8'(LEVEL_COUNT));
    assign w_mod_start = w_in_acc && (w_kind == KIND_TICK) && r_running
                         && (w_total != '0);
    assign o_cfg_ready = 1'b1;

    drmseq_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_count + 16'd1),
        .i_divisor  (w_total),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_running   <= 1'b0;
            r_level     <= '0;
            r_mode      <= MODE_OFF;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LEVEL_COUNT; i++) begin
                r_times[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                for (int i = 0; i < LEVEL_COUNT; i++) begin
                    if (i_cfg_index == CFG_IDX_W'(i)) begin
                        r_times[i] <= i_cfg_data;
                    end
                end
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_out_valid <= 1'b1;
                        case (w_kind)
                            KIND_TICK: begin
                                if (r_running) begin
                                    r_count <= r_count + 16'd1;
                                    if (w_total != '0) begin
                                        r_out_valid <= 1'b0;
                                        r_state     <= S_DIV;
                                    end
                                end
                            end
                            KIND_START: begin
                                if (w_level_ok && !(r_running && r_level == i_level[1:0])) begin
                                    r_level   <= i_level[1:0];
                                    r_count   <= '0;
                                    r_running <= 1'b1;
                                    if (r_mode == MODE_OFF) begin
                                        r_mode <= MODE_FWD;
                                    end
                                end
                            end
                            KIND_STOP: begin
                                r_running <= 1'b0;
                                r_mode    <= MODE_OFF;
                            end
                            KIND_MANFWD: r_mode <= MODE_FWD;
                            KIND_MANREV: r_mode <= MODE_REV;
                            KIND_MANOFF: r_mode <= MODE_OFF;
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_mod_done) begin
                        r_mode      <= w_phase;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_motor_mode      = r_mode;
    assign o_rotation_active = r_running;
    assign o_active_level    = r_level;
    assign o_elapsed_seconds = r_count;

    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !o_in_ready)
        else $error("Input word accepted during the remainder step.");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_DIV))
        else $error("Remainder unit finished outside the remainder step.");

    a_active_has_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rotation_active |-> (o_active_level != 2'd0))
        else $error("Rotation active without a level.");

    a_stop_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_kind == KIND_STOP)
        |=> (o_motor_mode == MODE_OFF && !o_rotation_active && o_out_valid))
        else $error("Stop word did not halt the motor.");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_motor_mode == MODE_OFF || o_motor_mode == MODE_FWD || o_motor_mode == MODE_REV))
        else $error("Illegal motor mode.");

endmodule

// ===== src/drmseq_mod.sv =====
module drmseq_mod
    import drmseq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SEC_W-1:0]   i_dividend,
    input  logic [TOTAL_W-1:0] i_divisor,
    output logic               o_done,
    output logic [TOTAL_W-1:0] o_rem
);

    logic                     r_busy;
    logic                     r_done;
    logic [$clog2(SEC_W)-1:0] r_cnt;
    logic [SEC_W-1:0]         r_quo;
    logic [TOTAL_W-1:0]       r_rem;
    logic [TOTAL_W-1:0]       r_div;
    logic [TOTAL_W:0]         w_trial;
    logic [TOTAL_W-1:0]       w_diff;

    assign w_trial = {r_rem, r_quo[SEC_W-1]};
    assign w_diff  = w_trial[TOTAL_W-1:0] - r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ($clog2(SEC_W))'(SEC_W - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[SEC_W-2:0], 1'b0};
                if (w_trial >= {1'b0, r_div}) begin
                    r_rem <= w_diff;
                end else begin
                    r_rem <= w_trial[TOTAL_W-1:0];
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== dv/tb.sv =====
module tb;
    import drmseq_pkg::*;

    localparam int LEVELS      = 3;
    localparam int MAX_REPORTS = 10;
    localparam int HALF_PERIOD = 6;

    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THREE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE       = 2'd3;

    typedef struct packed {
        t_mode            mode;
        logic             active;
        logic [1:0]       level;
        logic [SEC_W-1:0] secs;
    } t_drum_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic [2:0]           i_kind = 3'd0;
    logic [7:0]           i_level = 8'd0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TIME_W-1:0]    i_cfg_data = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [1:0]           o_motor_mode;
    logic                 o_rotation_active;
    logic [1:0]           o_active_level;
    logic [SEC_W-1:0]     o_elapsed_seconds;
    logic                 o_cfg_ready;

    // Predicted drum state, updated as each word is accepted.
    logic [TIME_W-1:0] pred_times [LEVELS];
    logic [SEC_W-1:0]  pred_count;
    logic              pred_running;
    logic [1:0]        pred_level;
    t_mode             pred_mode;

    t_drum_result pending_results [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int results_checked = 0;
    int words_sent = 0;
    int cfg_writes = 0;
    int zero_total_ticks = 0;
    int count_wraps = 0;
    int kind_seen [8];

    drum_reversing_motor_sequencer_top #(
        .LEVEL_COUNT(LEVELS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_level          (i_level),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_motor_mode     (o_motor_mode),
        .o_rotation_active(o_rotation_active),
        .o_active_level   (o_active_level),
        .o_elapsed_seconds(o_elapsed_seconds),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [TIME_W-1:0] pack_times(logic [7:0] fwd, logic [7:0] rev,
                                                     logic [7:0] pause);
        return {pause, rev, fwd};
    endfunction

    function automatic logic [TIME_W-1:0] random_times();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return TIME_W'($urandom);
            default: return pack_times(8'($urandom_range(6)), 8'($urandom_range(6)),
                                       8'($urandom_range(4)));
        endcase
    endfunction

    function automatic t_drum_result next_drum_result(logic [2:0] kind, logic [7:0] level);
        logic [TIME_W-1:0] times;
        int unsigned       fwd;
        int unsigned       rev;
        int unsigned       pause;
        int unsigned       total;
        int unsigned       pos;
        t_drum_result      res;
        case (kind)
            KIND_TICK: begin
                if (pred_running) begin
                    pred_count = pred_count + 1'b1;
                    if (pred_count == '0) begin
                        count_wraps++;
                    end
                    if (pred_level != 2'd0) begin
                        times = pred_times[pred_level - 2'd1];
                        fwd   = times[7:0];
                        rev   = times[15:8];
                        pause = times[23:16];
                        total = fwd + rev + 2 * pause;
                        if (total == 0) begin
                            zero_total_ticks++;
                        end else begin
                            pos = pred_count % total;
                            if (pos < fwd) begin
                                pred_mode = MODE_FWD;
                            end else if (pos < fwd + pause) begin
                                pred_mode = MODE_OFF;
                            end else if (pos < fwd + pause + rev) begin
                                pred_mode = MODE_REV;
                            end else begin
                                pred_mode = MODE_OFF;
                            end
                        end
                    end
                end
            end
            KIND_START: begin
                if (level >= 8'd1 && level <= LEVELS) begin
                    if (!(pred_running && pred_level == level)) begin
                        pred_level   = level[1:0];
                        pred_count   = '0;
                        pred_running = 1'b1;
                        if (pred_mode == MODE_OFF) begin
                            pred_mode = MODE_FWD;
                        end
                    end
                end
            end
            KIND_STOP: begin
                pred_running = 1'b0;
                pred_mode    = MODE_OFF;
            end
            KIND_MANFWD: pred_mode = MODE_FWD;
            KIND_MANREV: pred_mode = MODE_REV;
            KIND_MANOFF: pred_mode = MODE_OFF;
            default: ;
        endcase
        res.mode   = pred_mode;
        res.active = pred_running;
        res.level  = pred_level;
        res.secs   = pred_count;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_drum_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("%0t: result with no word outstanding: mode %0d active %0d",
                             $time, o_motor_mode, o_rotation_active);
                    $display("    level %0d seconds %0d", o_active_level, o_elapsed_seconds);
                end
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_motor_mode !== want.mode || o_rotation_active !== want.active ||
                    o_active_level !== want.level || o_elapsed_seconds !== want.secs) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: mismatch: mode %0d/%0d active %0d/%0d level %0d/%0d",
                                 $time, want.mode, o_motor_mode, want.active,
                                 o_rotation_active, want.level, o_active_level);
                        $display("    seconds %0d/%0d (expected/actual)",
                                 want.secs, o_elapsed_seconds);
                    end
                    mismatches++;
                end
            end
        end
    end

    task automatic send_word(logic [2:0] kind, logic [7:0] level);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_level    <= level;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(next_drum_result(kind, level));
        kind_seen[kind]++;
        words_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_times(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx < LEVELS) begin
            pred_times[idx] = data;
        end
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_word(KIND_TICK, 8'($urandom_range(255)));
        end else if (pick < 70) begin
            send_word(KIND_START, 8'($urandom_range(LEVELS, 1)));
        end else if (pick < 76) begin
            send_word(KIND_STOP, 8'($urandom_range(255)));
        end else if (pick < 88) begin
            send_word(3'($urandom_range(KIND_MANOFF, KIND_MANFWD)), 8'($urandom_range(255)));
        end else if (pick < 92) begin
            send_word($urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B,
                      8'($urandom_range(255)));
        end else begin
            send_word(KIND_START, 8'($urandom_range(255)));
        end
    endtask

    task automatic test_directed_events();
        write_times(REG_LEVEL_ONE, pack_times(8'd5, 8'd2, 8'd3));
        write_times(REG_LEVEL_TWO, '1);
        write_times(REG_LEVEL_THREE, '0);
        write_times(REG_SPARE, '1);
        send_word(KIND_TICK, 8'hFF);
        send_word(KIND_SPARE_A, 8'h00);
        send_word(KIND_SPARE_B, 8'hAA);
        send_word(KIND_START, 8'd0);
        send_word(KIND_START, 8'd4);
        send_word(KIND_START, 8'hFF);
        send_word(KIND_START, 8'd1);
        send_word(KIND_START, 8'd1);
        repeat (6) send_word(KIND_TICK, 8'h55);
        send_word(KIND_MANREV, 8'h00);
        send_word(KIND_START, 8'd2);
        send_word(KIND_TICK, 8'h00);
        // Level three has an empty cycle, so ticks must leave the drive alone.
        send_word(KIND_START, 8'd3);
        send_word(KIND_TICK, 8'h0F);
        send_word(KIND_MANOFF, 8'hF0);
        send_word(KIND_TICK, 8'h33);
        send_word(KIND_MANFWD, 8'hCC);
        send_word(KIND_STOP, 8'h81);
        send_word(KIND_TICK, 8'h7E);
        send_word(KIND_START, 8'd1);
        wait_idle();
    endtask

    task automatic test_phase_walk();
        write_times(REG_LEVEL_ONE, pack_times(8'd0, 8'd3, 8'd2));
        write_times(REG_LEVEL_TWO, pack_times(8'd4, 8'd0, 8'd1));
        write_times(REG_LEVEL_THREE, pack_times(8'd0, 8'd0, 8'd2));
        for (int lvl = 1; lvl <= LEVELS; lvl++) begin
            send_word(KIND_STOP, 8'($urandom_range(255)));
            send_word(KIND_START, 8'(lvl));
            repeat (24) send_word(KIND_TICK, 8'($urandom_range(255)));
        end
        send_word(KIND_STOP, 8'($urandom_range(255)));
        wait_idle();
    endtask

    task automatic test_random_traffic(int sender_idle, int receiver_stall);
        send_idle_pct = sender_idle;
        stall_pct = receiver_stall;
        for (int r = 0; r < LEVELS; r++) begin
            write_times(REG_LEVEL_ONE + CFG_IDX_W'(r), random_times());
        end
        if ($urandom_range(3) == 0) begin
            write_times(REG_SPARE, TIME_W'($urandom));
        end
        for (int n = 0; n < 340; n++) begin
            if (n % 90 == 89) begin
                write_times(CFG_IDX_W'($urandom_range(3)), random_times());
            end
            send_random_word();
        end
        wait_idle();
    endtask

    initial begin
        for (int r = 0; r < LEVELS; r++) begin
            pred_times[r] = '0;
        end
        pred_count   = '0;
        pred_running = 1'b0;
        pred_level   = 2'd0;
        pred_mode    = MODE_OFF;
        for (int k = 0; k < 8; k++) begin
            kind_seen[k] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_events();
        test_phase_walk();
        test_random_traffic(0, 0);
        test_random_traffic(72, 0);
        test_random_traffic(0, 72);
        test_random_traffic(24, 24);
        repeat (20) @(posedge i_clk);
        $display("Covered %0d words (%0d ticks, %0d starts, %0d stops, %0d unused kinds).",
                 words_sent, kind_seen[KIND_TICK], kind_seen[KIND_START],
                 kind_seen[KIND_STOP], kind_seen[KIND_SPARE_A] + kind_seen[KIND_SPARE_B]);
        $display("Made %0d register writes, checked %0d results, saw %0d empty-cycle ticks.",
                 cfg_writes, results_checked, zero_total_ticks);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("drum_reversing_motor_sequencer_top regression: pass");
        end else begin
            $display("drum_reversing_motor_sequencer_top regression: fail");
        end
        $finish;
    end

    initial begin
        #(2 * HALF_PERIOD * 6_000_000);
        $display("drum_reversing_motor_sequencer_top regression: fail");
        $finish;
    end

endmodule

// ===== drum_reversing_motor_sequencer_top.f =====
src/drmseq_pkg.sv
src/drmseq_mod.sv
src/drum_reversing_motor_sequencer_top.sv
dv/tb.sv
